[rtl/core/bilinear_texel_sampler_defines.svh]
// Assertion macros shared by the bilinear texel sampler checkers.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef BILINEAR_TEXEL_SAMPLER_DEFINES_SVH
`define BILINEAR_TEXEL_SAMPLER_DEFINES_SVH

// same-cycle implication, ignored while reset is held
`define BTS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bilinear_texel_sampler check failed");

// next-cycle implication, ignored while reset is held
`define BTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bilinear_texel_sampler check failed");

// next-cycle implication that also holds across reset
`define BTS_ASSERT_NEXT_ALL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bilinear_texel_sampler check failed");

`endif

[rtl/core/bts_pkg.sv]
// Shared types and constants of the bilinear texel sampler.
// No dependencies; used by the front end, queue, back end and top level.
package bts_pkg;

  localparam int ADDR_W  = 16;
  localparam int RGB_W   = 24;
  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int REG_W   = 9;
  localparam int WGT_W   = 8;
  localparam int CHAN_W  = 16;
  localparam int NCHAN   = 3;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic              is_write;
    logic [ADDR_W-1:0] addr_c;
    logic [ADDR_W-1:0] addr_r;
    logic [ADDR_W-1:0] addr_u;
    logic [ADDR_W-1:0] addr_q;
    logic [RGB_W-1:0]  rgb;
    logic [WGT_W-1:0]  wx;
    logic [WGT_W-1:0]  wy;
    logic              has_right;
    logic              has_up;
  } bts_entry_t;

endpackage

[rtl/core/bts_front.sv]
// Front end: configuration registers, coordinate scaling and address generation.
// Depends on bts_pkg.
module bts_front #(
  parameter int MAX_SIDE = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [bts_pkg::REG_W-1:0]       cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [bts_pkg::ADDR_W-1:0]      texel_addr,
  input  logic [bts_pkg::RGB_W-1:0]       texel_rgb,
  input  logic signed [bts_pkg::COORD_W-1:0] coord_u,
  input  logic signed [bts_pkg::COORD_W-1:0] coord_v,
  output logic                            push_valid,
  input  logic                            push_ready,
  output bts_pkg::bts_entry_t             push_entry
);

  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int SP = bts_pkg::FRAC_W + SW;
  localparam int PW = 2 * SW;

  function automatic logic [SW-1:0] clamp_side(logic [bts_pkg::REG_W-1:0] r);
    if (r == '0) return SW'(1);
    if (32'(r) > 32'(MAX_SIDE)) return SW'(MAX_SIDE);
    return SW'(r);
  endfunction

  logic [bts_pkg::REG_W-1:0] texture_width, texture_height;
  logic [SW-1:0] side_w, side_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      texture_width  <= bts_pkg::REG_W'(1);
      texture_height <= bts_pkg::REG_W'(1);
    end else if (cfg_wr_en) begin
      if (cfg_index == bts_pkg::CFG_WIDTH) texture_width <= cfg_wr_data;
      else texture_height <= cfg_wr_data;
    end
  end

  assign side_w = clamp_side(texture_width);
  assign side_h = clamp_side(texture_height);

  // stage 1: input register
  logic v1, t1;
  logic [bts_pkg::ADDR_W-1:0] a1;
  logic [bts_pkg::RGB_W-1:0]  rgb1;
  logic [bts_pkg::FRAC_W-1:0] fu1, fv1;
  // stage 2: scaled coordinates
  logic v2, t2;
  logic [bts_pkg::ADDR_W-1:0] a2;
  logic [bts_pkg::RGB_W-1:0]  rgb2;
  logic [SP-1:0] su2, sv2;
  // stage 3: texel index, weights, row base
  logic v3, t3;
  logic [bts_pkg::ADDR_W-1:0] a3, base3;
  logic [bts_pkg::RGB_W-1:0]  rgb3;
  logic [SW-1:0] col3;
  logic [bts_pkg::WGT_W-1:0] wx3, wy3;
  logic hr3, hu3;

  logic rdy1, rdy2, rdy3;
  logic [SW-1:0] col2, row2;
  logic [PW-1:0] row_prod;

  assign rdy3 = !v3 || push_ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  assign col2 = su2[bts_pkg::FRAC_W +: SW];
  assign row2 = sv2[bts_pkg::FRAC_W +: SW];
  assign row_prod = PW'(row2) * PW'(side_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      t1   <= req_type;
      a1   <= texel_addr;
      rgb1 <= texel_rgb;
      fu1  <= coord_u[bts_pkg::FRAC_W-1:0];
      fv1  <= coord_v[bts_pkg::FRAC_W-1:0];
    end
    if (rdy2) begin
      t2   <= t1;
      a2   <= a1;
      rgb2 <= rgb1;
      su2  <= SP'(fu1) * SP'(side_w);
      sv2  <= SP'(fv1) * SP'(side_h);
    end
    if (rdy3) begin
      t3    <= t2;
      a3    <= a2;
      rgb3  <= rgb2;
      col3  <= col2;
      wx3   <= su2[15:8];
      wy3   <= sv2[15:8];
      hr3   <= ((SW+1)'(col2) + (SW+1)'(1)) < (SW+1)'(side_w);
      hu3   <= ((SW+1)'(row2) + (SW+1)'(1)) < (SW+1)'(side_h);
      base3 <= bts_pkg::ADDR_W'(row_prod);
    end
  end

  logic [bts_pkg::ADDR_W-1:0] addr_c, addr_u;

  always_comb begin
    addr_c = (t3 == bts_pkg::REQ_WRITE) ? a3 : base3 + bts_pkg::ADDR_W'(col3);
    addr_u = addr_c + bts_pkg::ADDR_W'(side_w);
    push_entry.is_write  = (t3 == bts_pkg::REQ_WRITE);
    push_entry.addr_c    = addr_c;
    push_entry.addr_r    = addr_c + bts_pkg::ADDR_W'(1);
    push_entry.addr_u    = addr_u;
    push_entry.addr_q    = addr_u + bts_pkg::ADDR_W'(1);
    push_entry.rgb       = rgb3;
    push_entry.wx        = wx3;
    push_entry.wy        = wy3;
    push_entry.has_right = hr3;
    push_entry.has_up    = hu3;
  end

  assign push_valid = v3;

endmodule

[rtl/core/bts_queue.sv]
// Four-entry queue between the front end and the texel back end.
// Depends on bts_pkg.
module bts_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  bts_pkg::bts_entry_t push_entry,
  output logic                pop_valid,
  input  logic                pop_ready,
  output bts_pkg::bts_entry_t pop_entry
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  bts_pkg::bts_entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic do_push, do_pop;

  assign push_ready = (count != (PTR_W+1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

endmodule

[rtl/core/bts_back.sv]
// Back end: four-copy texel store, edge substitution and two blend stages.
// Depends on bts_pkg.
module bts_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  output logic                       q_ready,
  input  bts_pkg::bts_entry_t        q_entry,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [bts_pkg::CHAN_W-1:0] red_out,
  output logic [bts_pkg::CHAN_W-1:0] green_out,
  output logic [bts_pkg::CHAN_W-1:0] blue_out
);

  localparam int DEPTH = 1 << bts_pkg::ADDR_W;
  localparam int LW = 17;
  localparam int HW = 25;

  // one copy per neighbour so each gets its own read port
  logic [bts_pkg::RGB_W-1:0] mem_c [DEPTH];
  logic [bts_pkg::RGB_W-1:0] mem_r [DEPTH];
  logic [bts_pkg::RGB_W-1:0] mem_u [DEPTH];
  logic [bts_pkg::RGB_W-1:0] mem_q [DEPTH];

  logic [bts_pkg::RGB_W-1:0] rd_c, rd_r, rd_u, rd_q;
  logic vm, hr_m, hu_m;
  logic [bts_pkg::WGT_W-1:0] wx_m, wy_m, wy_1;
  logic v1;
  logic [bts_pkg::NCHAN-1:0][bts_pkg::CHAN_W-1:0] lo_next, hi_next, lo_1, hi_1, res_next;

  logic rdy_o, rdy_1, rdy_m, pop, wr;

  assign rdy_o   = !out_valid || out_ready;
  assign rdy_1   = !v1 || rdy_o;
  assign rdy_m   = !vm || rdy_1;
  assign q_ready = rdy_m;
  assign pop     = q_valid && rdy_m;
  assign wr      = pop && q_entry.is_write;

  always_ff @(posedge clk) begin
    if (wr) mem_c[q_entry.addr_c] <= q_entry.rgb;
    if (rdy_m) rd_c <= mem_c[q_entry.addr_c];
  end
  always_ff @(posedge clk) begin
    if (wr) mem_r[q_entry.addr_c] <= q_entry.rgb;
    if (rdy_m) rd_r <= mem_r[q_entry.addr_r];
  end
  always_ff @(posedge clk) begin
    if (wr) mem_u[q_entry.addr_c] <= q_entry.rgb;
    if (rdy_m) rd_u <= mem_u[q_entry.addr_u];
  end
  always_ff @(posedge clk) begin
    if (wr) mem_q[q_entry.addr_c] <= q_entry.rgb;
    if (rdy_m) rd_q <= mem_q[q_entry.addr_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm        <= 1'b0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_m) vm <= pop && !q_entry.is_write;
      if (rdy_1) v1 <= vm;
      if (rdy_o) out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_m) begin
      hr_m <= q_entry.has_right;
      hu_m <= q_entry.has_up;
      wx_m <= q_entry.wx;
      wy_m <= q_entry.wy;
    end
    if (rdy_1) begin
      lo_1 <= lo_next;
      hi_1 <= hi_next;
      wy_1 <= wy_m;
    end
    if (rdy_o) begin
      red_out   <= res_next[0];
      green_out <= res_next[1];
      blue_out  <= res_next[2];
    end
  end

  // replace neighbours past the edge by the center texel, then blend rows
  always_comb begin
    logic [bts_pkg::RGB_W-1:0] c, r, p, q;
    logic [8:0] iwx;
    c   = rd_c;
    r   = hr_m ? rd_r : rd_c;
    p   = hu_m ? rd_u : rd_c;
    q   = (hr_m && hu_m) ? rd_q : rd_c;
    iwx = 9'd256 - 9'(wx_m);
    for (int k = 0; k < bts_pkg::NCHAN; k++) begin
      lo_next[k] = bts_pkg::CHAN_W'(LW'(c[8*k +: 8]) * LW'(iwx) + LW'(r[8*k +: 8]) * LW'(wx_m));
      hi_next[k] = bts_pkg::CHAN_W'(LW'(p[8*k +: 8]) * LW'(iwx) + LW'(q[8*k +: 8]) * LW'(wx_m));
    end
  end

  // vertical blend, truncated back to 8.8
  always_comb begin
    logic [8:0] iwy;
    logic [HW-1:0] acc;
    iwy = 9'd256 - 9'(wy_1);
    acc = '0;
    for (int k = 0; k < bts_pkg::NCHAN; k++) begin
      acc = HW'(lo_1[k]) * HW'(iwy) + HW'(hi_1[k]) * HW'(wy_1);
      res_next[k] = acc[8 +: bts_pkg::CHAN_W];
    end
  end

endmodule

[rtl/core/bilinear_texel_sampler.sv]
// Top level of the bilinear texel sampler.
// Depends on bts_pkg, bts_front, bts_queue and bts_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries write items (req_type 0:
//   texel_rgb stored at texel_addr) and sample items (req_type 1: Q16.16
//   coord_u/coord_v). Output channel (out_valid/out_ready) returns one
//   8.8 RGB result per sample, in order; writes return nothing.
//   Configuration: cfg_wr_en with cfg_index 0 (width) or 1 (height) and
//   cfg_wr_data; write only while the block is idle.
//   Throughput: one item per cycle while out_ready stays high, set by the
//   texel store held in four copies, each with a read port for one neighbour.
//   Registered steps from the accepting edge to out_valid: coordinate
//   scaling, row base multiply, the queue write, the store read, the
//   horizontal blend and the vertical blend register.
//   A four-entry queue separates front and back; when the receiver stalls
//   the back end holds, the queue fills and in_ready drops.
//   Reset clears the pipelines, the queue and sets width and height to 1;
//   store contents stay undefined until written, with no clearing pass.
module bilinear_texel_sampler #(
  parameter int MAX_SIDE = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic                               cfg_index,
  input  logic [bts_pkg::REG_W-1:0]          cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               req_type,
  input  logic [bts_pkg::ADDR_W-1:0]         texel_addr,
  input  logic [bts_pkg::RGB_W-1:0]          texel_rgb,
  input  logic signed [bts_pkg::COORD_W-1:0] coord_u,
  input  logic signed [bts_pkg::COORD_W-1:0] coord_v,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [bts_pkg::CHAN_W-1:0]         red_out,
  output logic [bts_pkg::CHAN_W-1:0]         green_out,
  output logic [bts_pkg::CHAN_W-1:0]         blue_out
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  bts_pkg::bts_entry_t push_entry, pop_entry;

  bts_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk, .rst, .cfg_wr_en, .cfg_index, .cfg_wr_data,
    .in_valid, .in_ready, .req_type, .texel_addr, .texel_rgb, .coord_u, .coord_v,
    .push_valid, .push_ready, .push_entry
  );

  bts_queue u_queue (
    .clk, .rst, .push_valid, .push_ready, .push_entry,
    .pop_valid, .pop_ready, .pop_entry
  );

  bts_back u_back (
    .clk, .rst,
    .q_valid(pop_valid), .q_ready(pop_ready), .q_entry(pop_entry),
    .out_valid, .out_ready, .red_out, .green_out, .blue_out
  );

endmodule

[rtl/core/bts_checker.sv]
// Port-level checker for the bilinear texel sampler, bound to the top level.
// Depends on bilinear_texel_sampler_defines.svh.
`include "bilinear_texel_sampler_defines.svh"

module bts_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic req_type,
  input logic out_valid,
  input logic out_ready
);

  logic [7:0] pending;
  logic in_fire, out_fire;

  assign in_fire  = in_valid && in_ready && req_type;
  assign out_fire = out_valid && out_ready;

  // samples accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) pending <= '0;
    else pending <= pending + 8'(in_fire) - 8'(out_fire);
  end

  `BTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `BTS_ASSERT_NEXT_ALL(a_rst_idle, rst, !out_valid)
  `BTS_ASSERT_SAME(a_no_spurious, out_valid, pending != 8'd0)

endmodule

bind bilinear_texel_sampler bts_checker u_bts_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .req_type(req_type), .out_valid(out_valid), .out_ready(out_ready)
);
